/* design/ultrasonic_echo_distance_macros.svh */
// Assertion macros for the ultrasonic echo ranger checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ULTRASONIC_ECHO_DISTANCE_MACROS_SVH
`define ULTRASONIC_ECHO_DISTANCE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UECD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UECD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/uecd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and reset values for the ultrasonic echo ranger.
// No dependencies; used by every other file of the block but the macros header.
package uecd_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 4;
  localparam int unsigned TIMER_BITS_DEF   = 16;

  localparam logic [9:0]  OFFSET_CM_RST = 10'd40;
  localparam logic [3:0]  DIR_MASK_RST  = 4'd5;
  localparam logic [15:0] SCALE_RST     = 16'd1124;

  typedef enum logic {
    CMD_TRIGGER = 1'b0,
    CMD_EDGE    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_OFFSET_CM = 2'd0,
    REG_DIR_MASK  = 2'd1,
    REG_SCALE     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [9:0]  offset_cm;
    logic [3:0]  dir_mask;
    logic [15:0] scale_q16;
  } cfg_t;

  typedef struct packed {
    logic        updated;
    logic [1:0]  stored_direction;
    logic [15:0] distance_cm;
  } result_t;

endpackage

/* design/ultrasonic_echo_distance.sv */
`timescale 1ns / 1ps
// Top level of the four-channel ultrasonic echo ranger.
// Depends on uecd_pkg, uecd_cfg and uecd_core.
//
// Usage:
// Requests enter on the slave stream. tuser carries the command (trigger or
// echo edge); tdata carries direction, channel and the captured timer value.
// A trigger records the active direction. An edge on a channel alternately
// records the start time (rising) or measures the echo width (falling), scales
// it to centimeters with scale_q16, subtracts offset_cm on masked directions
// (saturating at zero) and reports it under the active direction.
// Every request produces exactly one result on the master stream; tuser is
// the updated flag, and direction and distance read as zero when it is low.
// A request passes through the input register and then the result register; one pass
// of logic (one 16x16 multiply, a subtract and a compare) sits between the two.
// Throughput is one request per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; s_axis_tready drops only when both are full.
// Reset clears all channels to expect a rising edge, the start time and the
// active direction to zero, and the registers to offset 40, mask 5, scale 1124.
// Configuration is to be written through the APB port only while the stream is idle; the block does not enforce it.
module ultrasonic_echo_distance #(
  parameter int unsigned NUM_CHANNELS = uecd_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned TIMER_BITS   = uecd_pkg::TIMER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // direction[7:0], channel[9:8], timer_count[25:10], 0
  input  logic [0:0]  s_axis_tuser,  // command[0]
  // Master stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // stored_direction[1:0], distance_cm[17:2], 0
  output logic [0:0]  m_axis_tuser,  // updated[0]
  // APB configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  uecd_pkg::cfg_t    cfg;
  uecd_pkg::result_t res;

  // Input register.
  logic               in_v_q, in_v_d;
  uecd_pkg::cmd_e     in_cmd_q;
  logic [7:0]         in_dir_q;
  logic [1:0]         in_ch_q;
  logic [15:0]        in_timer_q;

  // Result register.
  logic               out_v_q, out_v_d;
  uecd_pkg::result_t  out_res_q;

  logic               advance, take;

  // The request in the input register moves on whenever the result register
  // is empty or is being drained in this same cycle.
  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  assign in_v_d  = take || (in_v_q && !advance);
  assign out_v_d = advance || (out_v_q && !m_axis_tready);

  uecd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  uecd_core #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .TIMER_BITS   (TIMER_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .commit_i    (advance),
    .cmd_i       (in_cmd_q),
    .direction_i (in_dir_q),
    .channel_i   (in_ch_q),
    .timer_i     (in_timer_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_cmd_q   <= uecd_pkg::cmd_e'(s_axis_tuser[0]);
      in_dir_q   <= s_axis_tdata[7:0];
      in_ch_q    <= s_axis_tdata[9:8];
      in_timer_q <= s_axis_tdata[25:10];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_res_q.updated;
  assign m_axis_tdata  = {6'd0, out_res_q.distance_cm, out_res_q.stored_direction};

endmodule

/* design/uecd_cfg.sv */
`timescale 1ns / 1ps
// APB configuration registers of the ultrasonic echo ranger.
// Depends on uecd_pkg for register indexes, reset values and cfg_t.
module uecd_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output uecd_pkg::cfg_t   cfg_o
);

  uecd_pkg::cfg_t   cfg_q, cfg_d;
  uecd_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = uecd_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        uecd_pkg::REG_OFFSET_CM: cfg_d.offset_cm = pwdata[9:0];
        uecd_pkg::REG_DIR_MASK:  cfg_d.dir_mask  = pwdata[3:0];
        uecd_pkg::REG_SCALE:     cfg_d.scale_q16 = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      uecd_pkg::REG_OFFSET_CM: prdata = {22'd0, cfg_q.offset_cm};
      uecd_pkg::REG_DIR_MASK:  prdata = {28'd0, cfg_q.dir_mask};
      uecd_pkg::REG_SCALE:     prdata = {16'd0, cfg_q.scale_q16};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_cm <= uecd_pkg::OFFSET_CM_RST;
      cfg_q.dir_mask  <= uecd_pkg::DIR_MASK_RST;
      cfg_q.scale_q16 <= uecd_pkg::SCALE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/uecd_core.sv */
`timescale 1ns / 1ps
// Per-request ranging logic: channel edge tracking, echo width, scaling, offset.
// Depends on uecd_pkg for cmd_e, cfg_t and result_t.
module uecd_core #(
  parameter int unsigned NUM_CHANNELS = uecd_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned TIMER_BITS   = uecd_pkg::TIMER_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               commit_i,
  input  uecd_pkg::cmd_e     cmd_i,
  input  logic [7:0]         direction_i,
  input  logic [1:0]         channel_i,
  input  logic [15:0]        timer_i,
  input  uecd_pkg::cfg_t     cfg_i,
  output uecd_pkg::result_t  res_o
);

  // The timer field is 16 bits, so a wider timer still only sees 16 bits.
  localparam int unsigned TW = (TIMER_BITS < 16) ? TIMER_BITS : 16;

  logic [NUM_CHANNELS-1:0] wait_q, wait_d;
  logic [TW-1:0]           start_q, start_d;
  logic [7:0]              active_q, active_d;

  logic [NUM_CHANNELS-1:0] ch_sel;
  logic                    ch_valid, ch_waiting;
  logic [TW-1:0]           now, elapsed;
  logic                    wrapped;
  logic [TW+15:0]          product;
  logic [15:0]             raw_cm, offset16, cm;
  logic                    dir_in_range, offset_en, falling, upd;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ch_sel[i] = (32'(channel_i) == i);
    end
  end

  assign ch_valid   = |ch_sel;
  assign ch_waiting = |(ch_sel & wait_q);

  // A wrapped timer counts to all ones and not through zero, hence one tick short.
  assign now     = timer_i[TW-1:0];
  assign wrapped = now < start_q;
  assign elapsed = now - start_q - TW'(wrapped);
  assign product = (TW+16)'(elapsed) * (TW+16)'(cfg_i.scale_q16);
  assign raw_cm  = 16'(product[TW+15:16]);

  assign dir_in_range = 32'(active_q) < NUM_CHANNELS;
  assign offset_en    = (active_q < 8'd4) && cfg_i.dir_mask[active_q[1:0]];
  assign offset16     = 16'(cfg_i.offset_cm);

  always_comb begin
    cm = raw_cm;
    if (offset_en) begin
      cm = (raw_cm > offset16) ? (raw_cm - offset16) : 16'd0;
    end
  end

  assign falling = (cmd_i == uecd_pkg::CMD_EDGE) && ch_valid && ch_waiting;
  assign upd     = falling && dir_in_range;

  always_comb begin
    res_o.updated          = upd;
    res_o.stored_direction = upd ? active_q[1:0] : 2'd0;
    res_o.distance_cm      = upd ? cm : 16'd0;
  end

  always_comb begin
    wait_d   = wait_q;
    start_d  = start_q;
    active_d = active_q;
    if (commit_i) begin
      if (cmd_i == uecd_pkg::CMD_TRIGGER) begin
        active_d = direction_i;
      end else if (ch_valid) begin
        if (!ch_waiting) begin
          start_d = now;
          wait_d  = wait_q | ch_sel;
        end else begin
          wait_d  = wait_q & ~ch_sel;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q   <= '0;
      start_q  <= '0;
      active_q <= '0;
    end else begin
      wait_q   <= wait_d;
      start_q  <= start_d;
      active_q <= active_d;
    end
  end

endmodule

/* design/uecd_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the ultrasonic echo ranger, bound to the top level.
// Depends on uecd_pkg and ultrasonic_echo_distance_macros.svh.
`include "ultrasonic_echo_distance_macros.svh"

module uecd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic scale_wr, scale_rd;

  assign scale_wr = psel && penable && pwrite && (paddr[3:2] == uecd_pkg::REG_SCALE);
  assign scale_rd = psel && !pwrite && (paddr[3:2] == uecd_pkg::REG_SCALE);

  // A stalled result keeps its valid and its payload.
  `UECD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "stalled result changed")

  // The input side only backs up when the output side is full and stalled.
  `UECD_ASSERT_SAME(a_in_stall_cause, s_axis_tvalid && !s_axis_tready,
    m_axis_tvalid && !m_axis_tready,
    "input stalled while output could drain")

  // A result that updated nothing carries zero direction and distance.
  `UECD_ASSERT_SAME(a_no_update_zero, m_axis_tvalid && !m_axis_tuser[0],
    m_axis_tdata == 24'd0,
    "non-update result carries data")

  // A scale write is visible to a read in the following cycle.
  `UECD_ASSERT_NEXT(a_scale_readback, scale_wr,
    !scale_rd || (prdata == {16'd0, $past(pwdata[15:0])}),
    "scale register readback mismatch")

endmodule

bind ultrasonic_echo_distance uecd_checker u_uecd_checker (.*);
